/* hdl/itoa_pkg.sv */
// ============================================================================
// itoa_pkg
// Shared types, widths and character codes for the integer-to-ASCII block.
// ============================================================================
package itoa_pkg;

    // Operand width, fixed by the transaction payload
    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for 2^VALUE_WIDTH (log10(2) ~ 0.30103)
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIGIT_BITS = NUM_DIGITS * 4;

    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
    localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_HEX_A = 8'd97;

    localparam logic FUNC_SDEC = 1'b0;
    localparam logic FUNC_HEX  = 1'b1;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   func;
    } t_in_item;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic [3:0] char_count;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    // Command from the sequencer to the digit register
    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic dabble;
        logic shift;
    } t_digit_cmd;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CHAR_ZERO + {4'd0, d};
        end else begin
            ch = CHAR_HEX_A + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

/* hdl/itoa_digit_unit.sv */
// ============================================================================
// itoa_digit_unit
// Digit register with one shared shift-and-correct unit: binary to BCD by
// shift-add-3, direct nibble load for hex, and a one-digit left shift.
// ============================================================================
module itoa_digit_unit
    import itoa_pkg::*;
(
    input  logic                   i_clk,
    input  t_digit_cmd             i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic [3:0]             o_top_digit
);

    logic [DIGIT_BITS-1:0]  r_bcd;
    logic [DIGIT_BITS-1:0]  n_bcd;
    logic [VALUE_WIDTH-1:0] r_bin;
    logic [VALUE_WIDTH-1:0] n_bin;
    logic [DIGIT_BITS-1:0]  w_adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        priority if (i_cmd.load_dec) begin
            n_bcd = '0;
            n_bin = i_value;
        end else if (i_cmd.load_hex) begin
            n_bcd = DIGIT_BITS'(i_value);
        end else if (i_cmd.dabble) begin
            n_bcd = {w_adj[DIGIT_BITS-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end else if (i_cmd.shift) begin
            n_bcd = {r_bcd[DIGIT_BITS-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_top_digit = r_bcd[DIGIT_BITS-1 -: 4];

endmodule

/* hdl/integer_to_ascii_digits.sv */
// ============================================================================
// integer_to_ascii_digits
// Prints one operand as ASCII characters, signed decimal or lowercase hex,
// most significant digit first, one character per strobe.
// ============================================================================
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------
//  command   | start / busy         | i_in  : value, func
//  result    | o_strobe (one cycle) | o_out : ascii_char, char_count, last
//
//  Decimal: the shift-add-3 loop runs one bit per cycle, then the digit
//  register is walked one digit per cycle.
//  Hex skips the loop and only walks the digit register.
//  Reset: synchronous, active low; returns the sequencer to idle.
//  Stalls: the receiver cannot stall; each character is shown for one cycle.
//  A new transaction may be taken in the cycle the last character leaves.
//
module integer_to_ascii_digits
    import itoa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_in,
    output logic      o_strobe,
    output t_out_item o_out
);

    t_state              r_state;
    t_state              n_state;
    logic [LEFT_W-1:0]   r_left;
    logic [LEFT_W-1:0]   n_left;
    logic [STEP_W-1:0]   r_steps;
    logic [STEP_W-1:0]   n_steps;
    logic [3:0]          r_cnt;
    logic [3:0]          n_cnt;
    logic                r_strobe;
    logic                n_strobe;
    t_out_item           r_out;
    t_out_item           n_out;
    t_digit_cmd          w_cmd;
    logic [3:0]          w_top;
    logic                w_accept;
    logic                w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;

    assign w_accept = start && (r_state == S_IDLE);
    // Negative only in signed decimal mode; magnitude is negation mod 2^W
    assign w_neg    = (i_in.func == FUNC_SDEC) && i_in.value[VALUE_WIDTH-1];
    assign w_mag    = w_neg ? (~i_in.value + VALUE_WIDTH'(1)) : i_in.value;

    itoa_digit_unit u_digits (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_value     (w_mag),
        .o_top_digit (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_left   <= '0;
            r_steps  <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_left   <= n_left;
            r_steps  <= n_steps;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_steps  = r_steps;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_out    = r_out;
        w_cmd    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_steps = STEP_W'(VALUE_WIDTH);
                    if (i_in.func == FUNC_HEX) begin
                        w_cmd.load_hex = 1'b1;
                        n_state        = S_SKIP;
                        n_cnt          = 4'd0;
                    end else begin
                        w_cmd.load_dec = 1'b1;
                        n_state        = S_CONV;
                        // Send the sign straight away, ahead of any digit
                        if (w_neg) begin
                            n_strobe         = 1'b1;
                            n_out.ascii_char = CHAR_MINUS;
                            n_out.char_count = 4'd1;
                            n_out.last       = 1'b0;
                            n_cnt            = 4'd1;
                        end else begin
                            n_cnt = 4'd0;
                        end
                    end
                end
            end

            S_CONV: begin
                w_cmd.dabble = 1'b1;
                n_steps      = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    n_state = S_SKIP;
                end
            end

            S_SKIP, S_EMIT: begin
                w_cmd.shift = 1'b1;
                n_left      = r_left - LEFT_W'(1);
                // Drop leading zeros but always keep the final digit
                if ((r_state == S_SKIP) && (w_top == 4'd0) && (r_left != LEFT_W'(1))) begin
                    n_state = S_SKIP;
                end else begin
                    n_strobe         = 1'b1;
                    n_cnt            = r_cnt + 4'd1;
                    n_out.ascii_char = digit_char(w_top);
                    n_out.char_count = r_cnt + 4'd1;
                    n_out.last       = (r_left == LEFT_W'(1));
                    n_state          = (r_left == LEFT_W'(1)) ? S_IDLE : S_EMIT;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // The final character leaves with the sequencer already idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.last |-> !busy)
        else $error("last character while still busy");

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted transaction did not start");

    // The sign can only be the first character of a run
    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_out.ascii_char == CHAR_MINUS) |-> (o_out.char_count == 4'd1))
        else $error("minus sign not first");

    // The digit walk never overruns the digit register
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP) || (r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit counter underflow");

    // A character in flight is never counted as zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out.char_count != 4'd0))
        else $error("character count of zero");

endmodule
